@@ rtl/core/mi3_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants and types of the 3x3 matrix inverse: entry count,
// cofactor operand tables and the flag bundle carried through the divider.
// ----------------------------------------------------------------------------
package mi3_pkg;

   localparam int unsigned NUM_ENTRIES = 9;

   typedef logic [3:0] idx_type;

   // cofactor e = a[P] * a[S] - a[Q] * a[R], flat row-major indexes
   localparam idx_type COF_P [NUM_ENTRIES] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
   localparam idx_type COF_Q [NUM_ENTRIES] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
   localparam idx_type COF_R [NUM_ENTRIES] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};
   localparam idx_type COF_S [NUM_ENTRIES] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};

   // per-item flags that ride along the divider stages
   typedef struct packed {
      logic [NUM_ENTRIES-1:0] neg;
      logic [NUM_ENTRIES-1:0] big;
      logic                   singular;
   } flags_type;

endpackage

@@ rtl/core/mi3_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_if
// Valid/ready channels of the matrix inverse: matrix items in, inverse
// items out.
// ----------------------------------------------------------------------------
interface mi3_req_if #(parameter int WORD_BITS = 32);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

   modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                   input ready);
   modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                   output ready);
endinterface

interface mi3_rsp_if #(parameter int WORD_BITS = 32);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
   logic                        singular;
   logic                        overflowed;

   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   singular, overflowed, input ready);
   modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   singular, overflowed, output ready);
endinterface

@@ rtl/core/matrix_inverse_3x3.sv @@
`timescale 1ns / 1ps
// Throughput: one item per cycle when the receiver does not stall; set by the
// fully pipelined divider, which spends one stage per quotient bit on all nine
// entries in parallel.
// Stalls freeze only the stages that hold an item; bubbles are squeezed out.
// Reset (synchronous) clears every stage valid bit; payload is not reset.
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Inverse of a signed fixed-point 3x3 matrix by the adjugate: exact
// cofactors and determinant, pipelined restoring division, saturation.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   mi3_req_if.sink  req,
   mi3_rsp_if.source rsp
);

   localparam int NE  = mi3_pkg::NUM_ENTRIES;
   localparam int PW  = 2 * WORD_BITS;
   localparam int CW  = 2 * WORD_BITS + 1;
   localparam int TW  = 3 * WORD_BITS + 1;
   localparam int DW  = 3 * WORD_BITS + 3;
   localparam int XA  = 2 * WORD_BITS + 2 * FRAC_BITS + 2;
   localparam int XB  = 4 * WORD_BITS + 3;
   localparam int XW  = (XA > XB) ? XA : XB;
   localparam int NST = 7;

   // front stage control
   logic          valid_ff [NST];
   logic          adv [NST];

   logic signed [WORD_BITS-1:0] a_in [NE];

   logic signed [PW-1:0]        ps_ff [NE];
   logic signed [PW-1:0]        qr_ff [NE];
   logic signed [WORD_BITS-1:0] row0_ff [3];
   logic signed [CW-1:0]        cof1_ff [NE];
   logic signed [WORD_BITS-1:0] row1_ff [3];
   logic signed [CW-1:0]        cof2_ff [NE];
   logic signed [CW-1:0]        plo_ff [3];
   logic signed [CW-1:0]        phi_ff [3];
   logic signed [CW-1:0]        cof3_ff [NE];
   logic signed [TW-1:0]        term_ff [3];
   logic signed [CW-1:0]        cof4_ff [NE];
   logic signed [DW-1:0]        det_ff;
   logic [XW-1:0]               num5_ff [NE];
   logic [XW-1:0]               den5_ff;
   logic [NE-1:0]               neg5_ff;
   logic                        zero5_ff;
   logic [NE-1:0]               big_in;
   logic [XW-1:0]               num6_ff [NE];
   logic [XW-1:0]               den6_ff;
   mi3_pkg::flags_type          flags6_ff;

   // divider chain, index 0 is the entry point
   logic                 dv_valid [WORD_BITS+1];
   logic                 dv_ready [WORD_BITS+1];
   logic [XW-1:0]        dv_rem [WORD_BITS+1][NE];
   logic [WORD_BITS-1:0] dv_quo [WORD_BITS+1][NE];
   logic [XW-1:0]        dv_den [WORD_BITS+1];
   mi3_pkg::flags_type   dv_flags [WORD_BITS+1];

   // result register
   logic                        out_valid_ff;
   logic                        out_adv;
   logic signed [WORD_BITS-1:0] res_ff [NE];
   logic                        singular_ff;
   logic                        overflowed_ff;
   logic [WORD_BITS-1:0]        res_in [NE];
   logic                        overflowed_in;

   assign a_in = '{req.a00, req.a01, req.a02, req.a10, req.a11, req.a12,
                   req.a20, req.a21, req.a22};

   // ready ripples back from the result register
   always_comb begin
      for (int s = 0; s < NST - 1; s++) begin
         adv[s] = !valid_ff[s] || adv[s+1];
      end
      adv[NST-1] = !valid_ff[NST-1] || dv_ready[0];
   end
   assign req.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NST; s++) valid_ff[s] <= 1'b0;
      end else begin
         if (adv[0]) valid_ff[0] <= req.valid;
         for (int s = 1; s < NST; s++) begin
            if (adv[s]) valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   // stage 0: the eighteen cofactor products
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int e = 0; e < NE; e++) begin
            ps_ff[e] <= a_in[mi3_pkg::COF_P[e]] * a_in[mi3_pkg::COF_S[e]];
            qr_ff[e] <= a_in[mi3_pkg::COF_Q[e]] * a_in[mi3_pkg::COF_R[e]];
         end
         row0_ff <= '{a_in[0], a_in[1], a_in[2]};
      end
   end

   // stage 1: cofactors
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         for (int e = 0; e < NE; e++) begin
            cof1_ff[e] <= CW'(ps_ff[e]) - CW'(qr_ff[e]);
         end
         row1_ff <= row0_ff;
      end
   end

   // stage 2: first-row products split into low and high halves
   always_ff @(posedge clock) begin
      if (adv[2]) begin
         for (int j = 0; j < 3; j++) begin
            plo_ff[j] <= row1_ff[j] * $signed({1'b0, cof1_ff[3*j][WORD_BITS-1:0]});
            phi_ff[j] <= row1_ff[j] * $signed(cof1_ff[3*j][CW-1:WORD_BITS]);
         end
         cof2_ff <= cof1_ff;
      end
   end

   // stage 3: recombine the halves
   always_ff @(posedge clock) begin
      if (adv[3]) begin
         for (int j = 0; j < 3; j++) begin
            term_ff[j] <= (TW'(phi_ff[j]) <<< WORD_BITS) + TW'(plo_ff[j]);
         end
         cof3_ff <= cof2_ff;
      end
   end

   // stage 4: determinant
   always_ff @(posedge clock) begin
      if (adv[4]) begin
         det_ff  <= DW'(term_ff[0]) + DW'(term_ff[1]) + DW'(term_ff[2]);
         cof4_ff <= cof3_ff;
      end
   end

   // stage 5: magnitudes and quotient signs
   always_ff @(posedge clock) begin
      if (adv[5]) begin
         for (int e = 0; e < NE; e++) begin
            num5_ff[e] <= XW'(cof4_ff[e][CW-1] ? -cof4_ff[e] : cof4_ff[e]) << (2 * FRAC_BITS);
            neg5_ff[e] <= cof4_ff[e][CW-1] ^ det_ff[DW-1];
         end
         den5_ff  <= XW'(det_ff[DW-1] ? -det_ff : det_ff);
         zero5_ff <= (det_ff == '0);
      end
   end

   // quotient too big for the word
   always_comb begin
      for (int e = 0; e < NE; e++) begin
         big_in[e] = (num5_ff[e] >= (den5_ff << WORD_BITS));
      end
   end

   // stage 6: flags for the divider
   always_ff @(posedge clock) begin
      if (adv[6]) begin
         flags6_ff <= '{neg: neg5_ff, big: big_in, singular: zero5_ff};
         num6_ff   <= num5_ff;
         den6_ff   <= den5_ff;
      end
   end

   assign dv_valid[0] = valid_ff[NST-1];
   assign dv_rem[0]   = num6_ff;
   assign dv_den[0]   = den6_ff;
   assign dv_flags[0] = flags6_ff;
   assign dv_quo[0]   = '{default: '0};

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < WORD_BITS; k++) begin : g_div
      mi3_div_step #(
         .XW    (XW),
         .QW    (WORD_BITS),
         .SHIFT (WORD_BITS - 1 - k)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[k]),
         .in_ready  (dv_ready[k]),
         .rem_in    (dv_rem[k]),
         .quo_in    (dv_quo[k]),
         .den_in    (dv_den[k]),
         .flags_in  (dv_flags[k]),
         .valid_ff  (dv_valid[k+1]),
         .out_ready (dv_ready[k+1]),
         .rem_ff    (dv_rem[k+1]),
         .quo_ff    (dv_quo[k+1]),
         .den_ff    (dv_den[k+1]),
         .flags_ff  (dv_flags[k+1])
      );
   end

   assign out_adv            = !out_valid_ff || rsp.ready;
   assign dv_ready[WORD_BITS] = out_adv;

   // saturation, sign and the singular case
   always_comb begin
      logic [WORD_BITS-1:0] lim;
      logic [WORD_BITS-1:0] mag;
      logic                 sat;
      overflowed_in = 1'b0;
      for (int e = 0; e < NE; e++) begin
         lim = dv_flags[WORD_BITS].neg[e] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                          : {1'b0, {(WORD_BITS-1){1'b1}}};
         sat = dv_flags[WORD_BITS].big[e] || (dv_quo[WORD_BITS][e] > lim);
         mag = sat ? lim : dv_quo[WORD_BITS][e];
         res_in[e] = dv_flags[WORD_BITS].neg[e] ? -mag : mag;
         if (dv_flags[WORD_BITS].singular) res_in[e] = '0;
         overflowed_in = overflowed_in || sat;
      end
      if (dv_flags[WORD_BITS].singular) overflowed_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_adv) begin
         out_valid_ff <= dv_valid[WORD_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         for (int e = 0; e < NE; e++) res_ff[e] <= res_in[e];
         singular_ff   <= dv_flags[WORD_BITS].singular;
         overflowed_ff <= overflowed_in;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.r00        = res_ff[0];
   assign rsp.r01        = res_ff[1];
   assign rsp.r02        = res_ff[2];
   assign rsp.r10        = res_ff[3];
   assign rsp.r11        = res_ff[4];
   assign rsp.r12        = res_ff[5];
   assign rsp.r20        = res_ff[6];
   assign rsp.r21        = res_ff[7];
   assign rsp.r22        = res_ff[8];
   assign rsp.singular   = singular_ff;
   assign rsp.overflowed = overflowed_ff;

endmodule

@@ rtl/core/mi3_div_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_div_step
// One registered restoring-division stage: settles quotient bit SHIFT of
// all nine entries against the shared determinant magnitude.
// ----------------------------------------------------------------------------
module mi3_div_step #(
   parameter int XW    = 132,
   parameter int QW    = 32,
   parameter int SHIFT = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [XW-1:0]       rem_in [mi3_pkg::NUM_ENTRIES],
   input  logic [QW-1:0]       quo_in [mi3_pkg::NUM_ENTRIES],
   input  logic [XW-1:0]       den_in,
   input  mi3_pkg::flags_type  flags_in,
   output logic                valid_ff,
   input  logic                out_ready,
   output logic [XW-1:0]       rem_ff [mi3_pkg::NUM_ENTRIES],
   output logic [QW-1:0]       quo_ff [mi3_pkg::NUM_ENTRIES],
   output logic [XW-1:0]       den_ff,
   output mi3_pkg::flags_type  flags_ff
);

   logic [XW-1:0] sub_den;
   logic [XW:0]   trial_in [mi3_pkg::NUM_ENTRIES];
   logic [QW-1:0] quo_set_in [mi3_pkg::NUM_ENTRIES];

   // stage takes a new item when empty or when its item moves on
   assign in_ready = !valid_ff || out_ready;
   assign sub_den  = den_in << SHIFT;

   // trial subtract, borrow bit says the shifted divisor did not fit
   always_comb begin
      for (int e = 0; e < mi3_pkg::NUM_ENTRIES; e++) begin
         trial_in[e]          = {1'b0, rem_in[e]} - {1'b0, sub_den};
         quo_set_in[e]        = quo_in[e];
         quo_set_in[e][SHIFT] = !trial_in[e][XW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         den_ff   <= den_in;
         flags_ff <= flags_in;
         for (int e = 0; e < mi3_pkg::NUM_ENTRIES; e++) begin
            rem_ff[e] <= trial_in[e][XW] ? rem_in[e] : trial_in[e][XW-1:0];
            quo_ff[e] <= quo_set_in[e];
         end
      end
   end

endmodule

@@ rtl/core/mi3_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_check
// Port-level checks of the matrix inverse: flag consistency, result hold
// under stall and empty output after reset.
// ----------------------------------------------------------------------------
module mi3_check #(
   parameter int WORD_BITS = 32
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [WORD_BITS-1:0] rsp_r00,
   input logic [WORD_BITS-1:0] rsp_r11,
   input logic [WORD_BITS-1:0] rsp_r22,
   input logic                 rsp_singular,
   input logic                 rsp_overflowed
);

   // a singular item never reports saturation
   a_sing_no_ovf : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> !rsp_overflowed)
      else $error("singular item with overflow flag");

   // a singular item carries zeros on the diagonal entries
   a_sing_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_r00 == '0 && rsp_r11 == '0 && rsp_r22 == '0)
      else $error("singular item with nonzero entries");

   // a stalled result item holds
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_r00) && $stable(rsp_singular))
      else $error("result item changed under stall");

   // nothing is offered right after reset
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind matrix_inverse_3x3 mi3_check #(.WORD_BITS(WORD_BITS)) u_mi3_check (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_r00        (rsp.r00),
   .rsp_r11        (rsp.r11),
   .rsp_r22        (rsp.r22),
   .rsp_singular   (rsp.singular),
   .rsp_overflowed (rsp.overflowed)
);

@@ sim/matrix_inverse_3x3_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_checker
// Watches the matrix and inverse channels. Each accepted matrix is inverted
// exactly by the adjugate. The inverse is truncated toward zero and
// saturated, then queued. Each accepted inverse is compared field by field
// with the oldest queued inverse.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_checker (
   input  logic clock,
   input  logic reset,
   mi3_req_if   req_mon,
   mi3_rsp_if   rsp_mon,
   output int   errors,
   output int   pending
);

   typedef struct {
      logic signed [31:0] r [mi3_pkg::NUM_ENTRIES];
      logic               singular;
      logic               overflowed;
   } inverse_type;

   inverse_type inverses_due [$];

   // exact adjugate inverse, truncated toward zero, saturated to 32 bits
   function automatic inverse_type invert(input logic signed [31:0] a [mi3_pkg::NUM_ENTRIES]);
      logic signed [255:0] w [mi3_pkg::NUM_ENTRIES];
      logic signed [255:0] c [mi3_pkg::NUM_ENTRIES];
      logic signed [255:0] det, num;
      logic [255:0]        nmag, dmag, quo, lim;
      logic                neg;
      inverse_type         res;
      for (int i = 0; i < mi3_pkg::NUM_ENTRIES; i++) w[i] = a[i];
      c[0] = w[4] * w[8] - w[5] * w[7];
      c[1] = w[2] * w[7] - w[1] * w[8];
      c[2] = w[1] * w[5] - w[2] * w[4];
      c[3] = w[5] * w[6] - w[3] * w[8];
      c[4] = w[0] * w[8] - w[2] * w[6];
      c[5] = w[2] * w[3] - w[0] * w[5];
      c[6] = w[3] * w[7] - w[4] * w[6];
      c[7] = w[1] * w[6] - w[0] * w[7];
      c[8] = w[0] * w[4] - w[1] * w[3];
      det = w[0] * c[0] + w[1] * c[3] + w[2] * c[6];
      res.singular   = (det == 0);
      res.overflowed = 1'b0;
      for (int i = 0; i < mi3_pkg::NUM_ENTRIES; i++) begin
         if (res.singular) begin
            res.r[i] = '0;
         end else begin
            num  = c[i] <<< 32;
            neg  = num[255] ^ det[255];
            nmag = num[255] ? -num : num;
            dmag = det[255] ? -det : det;
            quo  = nmag / dmag;
            lim  = neg ? 256'h8000_0000 : 256'h7fff_ffff;
            if (quo > lim) begin
               quo = lim;
               res.overflowed = 1'b1;
            end
            res.r[i] = neg ? -quo[31:0] : quo[31:0];
         end
      end
      return res;
   endfunction

   assign pending = inverses_due.size();

   initial errors = 0;

   // queue the inverse of each accepted matrix
   always @(posedge clock) begin
      logic signed [31:0] m [mi3_pkg::NUM_ENTRIES];
      if (!reset && req_mon.valid && req_mon.ready) begin
         m = '{req_mon.a00, req_mon.a01, req_mon.a02, req_mon.a10, req_mon.a11,
               req_mon.a12, req_mon.a20, req_mon.a21, req_mon.a22};
         inverses_due.push_back(invert(m));
      end
   end

   // compare each accepted inverse with the oldest one due
   always @(posedge clock) begin
      inverse_type got, want;
      logic        bad;
      if (!reset && rsp_mon.valid && rsp_mon.ready) begin
         got.r = '{rsp_mon.r00, rsp_mon.r01, rsp_mon.r02, rsp_mon.r10, rsp_mon.r11,
                   rsp_mon.r12, rsp_mon.r20, rsp_mon.r21, rsp_mon.r22};
         got.singular   = rsp_mon.singular;
         got.overflowed = rsp_mon.overflowed;
         if (inverses_due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: inverse item with none due");
         end else begin
            want = inverses_due.pop_front();
            bad  = (got.singular !== want.singular) || (got.overflowed !== want.overflowed);
            for (int i = 0; i < mi3_pkg::NUM_ENTRIES; i++) bad |= (got.r[i] !== want.r[i]);
            if (bad) begin
               errors++;
               if (errors <= 10) begin
                  for (int i = 0; i < mi3_pkg::NUM_ENTRIES; i++)
                     if (got.r[i] !== want.r[i])
                        $display("ERROR: r%0d%0d expected %h actual %h",
                                 i / 3, i % 3, want.r[i], got.r[i]);
                  $display("ERROR: flags singular/overflowed expected %b%b actual %b%b",
                           want.singular, want.overflowed, got.singular, got.overflowed);
               end
            end
         end
      end
   end

endmodule

@@ sim/matrix_inverse_3x3_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_tb
// Drives directed and random matrices into the inverse block with random
// idle bursts on both channels. The checker beside the block predicts and
// compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_tb;

   localparam logic signed [31:0] ONE    = 32'sh0001_0000;
   localparam logic signed [31:0] MAXV   = 32'sh7fff_ffff;
   localparam logic signed [31:0] MINV   = 32'sh8000_0000;
   localparam int                 N_RAND = 1250;
   localparam int                 LIMIT  = 600000;

   typedef logic signed [31:0] matrix_type [mi3_pkg::NUM_ENTRIES];

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic quiet = 1'b0;
   int   errors, pending, cycles = 0;

   mi3_req_if req_ch ();
   mi3_rsp_if rsp_ch ();

   matrix_inverse_3x3 u_top (.clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch));

   matrix_inverse_3x3_checker u_checker (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .errors(errors), .pending(pending)
   );

   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver stalls in bursts, none in the quiet tail
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // present one matrix and hold it until accepted
   task automatic send_matrix(input matrix_type m);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      {req_ch.a00, req_ch.a01, req_ch.a02, req_ch.a10, req_ch.a11, req_ch.a12,
       req_ch.a20, req_ch.a21, req_ch.a22} <= {m[0], m[1], m[2], m[3], m[4],
                                              m[5], m[6], m[7], m[8]};
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // random matrix of one of several kinds
   function automatic matrix_type random_matrix();
      matrix_type m;
      int         kind, k;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < mi3_pkg::NUM_ENTRIES; i++) begin
         case (kind)
            0, 1: m[i] = $urandom();
            2, 3, 4: m[i] = $signed($urandom_range(0, 2 * 8 * 65536)) - 8 * 65536;
            5: m[i] = (i % 4 == 0) ? $signed($urandom_range(1, 4 * 65536))
                                   : $signed($urandom_range(0, 512)) - 256;
            6: m[i] = $signed($urandom_range(0, 64)) - 32;
            7: m[i] = ($urandom_range(0, 1) ? MAXV : MINV) - $urandom_range(0, 3);
            default: m[i] = $signed($urandom_range(0, 2 * 4 * 65536)) - 4 * 65536;
         endcase
      end
      // singular by a repeated or scaled row
      if (kind >= 8) begin
         k = int'($urandom_range(0, 6)) - 3;
         for (int j = 0; j < 3; j++) m[6 + j] = m[j] * k;
      end
      return m;
   endfunction

   initial begin
      matrix_type m;
      req_ch.valid = 1'b0;
      {req_ch.a00, req_ch.a01, req_ch.a02, req_ch.a10, req_ch.a11, req_ch.a12,
       req_ch.a20, req_ch.a21, req_ch.a22} = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: identity, scaled, zero, extremes, overflow, singular
      send_matrix('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
      send_matrix('{2 * ONE, 0, 0, 0, -ONE / 2, 0, 0, 0, 4 * ONE});
      send_matrix('{0, ONE, 0, ONE, 0, 0, 0, 0, -ONE});
      send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
      send_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1});
      send_matrix('{-1, 0, 0, 0, 1, 0, 0, 0, -1});
      send_matrix('{MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV});
      send_matrix('{MINV, 0, 0, 0, MINV, 0, 0, 0, MINV});
      send_matrix('{MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV});
      send_matrix('{MAXV, MAXV, 0, MINV, MAXV, 0, 0, 0, MINV});
      send_matrix('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
      send_matrix('{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                    7 * ONE, 8 * ONE, 9 * ONE});
      send_matrix('{ONE, 2 * ONE, 3 * ONE, 0, ONE, 4 * ONE, 5 * ONE, 6 * ONE, 0});
      send_matrix('{ONE, 0, 0, 0, 256, 0, 0, 0, ONE});
      send_matrix('{3, 1, 2, -1, 4, 7, 5, -6, 1});
      send_matrix('{MAXV, 1, 0, 1, MINV, 1, 0, 1, MAXV});
      send_matrix('{ONE, ONE, 0, ONE, ONE, 0, 0, 0, ONE});

      // random part, quiet tail at the end
      for (int n = 0; n < N_RAND; n++) begin
         if (n == N_RAND - 150) quiet = 1'b1;
         m = random_matrix();
         send_matrix(m);
      end
      req_ch.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/mi3_pkg.sv
rtl/core/mi3_if.sv
rtl/core/mi3_div_step.sv
rtl/core/matrix_inverse_3x3.sv
rtl/core/mi3_check.sv
sim/matrix_inverse_3x3_checker.sv
sim/matrix_inverse_3x3_tb.sv
